// File: hdl/cbpg_pkg.sv
// Shared types and constants for the cubic Bezier point generator.
// No dependencies; every other file of the block refers to this package.
`default_nettype none

package cbpg_pkg;

    // Coordinate format: signed Q16.16 in 32 bits
    localparam int COORD_W = 32;
    // Curve parameter t: unsigned with 16 fraction bits plus one integer bit for t = 1.0
    localparam int T_FRAC  = 16;
    localparam int T_W     = T_FRAC + 1;
    localparam int T_ONE   = 65536;
    // (b - a) * t fits in 50 signed bits, with room for the rounding constant
    localparam int PROD_W  = 50;
    // Point index and step count width
    localparam int IDX_W   = 6;
    localparam int TAB_DEPTH = 2 ** IDX_W;
    // Lerp stages: three levels of two register stages each
    localparam int PIPE_DEPTH = 6;

    localparam logic [IDX_W-1:0] STEP_RESET = 6'd25;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic [T_W-1:0]            t_tval;
    typedef logic [IDX_W-1:0]          t_idx;

    // The four points of one axis, ordered along the control polygon
    typedef struct packed {
        t_coord p0;
        t_coord c0;
        t_coord c1;
        t_coord p1;
    } t_axis_pts;

    // One evaluation issued by the sequencer and carried beside the lanes
    typedef struct packed {
        logic  valid;
        logic  last;
        t_idx  idx;
        t_tval t;
    } t_issue;

endpackage

`default_nettype wire

// File: hdl/cbpg_lerp.sv
// Two-stage linear interpolation a + round((b - a) * t) with saturation.
// Depends on cbpg_pkg for the coordinate and t types.
`default_nettype none

module cbpg_lerp (
    input  wire                i_clk,
    input  wire                i_en,
    input  cbpg_pkg::t_coord   i_a,
    input  cbpg_pkg::t_coord   i_b,
    input  cbpg_pkg::t_tval    i_t,
    output cbpg_pkg::t_coord   o_y
);

    logic signed [cbpg_pkg::COORD_W:0]     w_diff;
    logic signed [cbpg_pkg::T_W:0]         w_t;
    logic signed [cbpg_pkg::PROD_W-1:0]    w_prod;
    logic signed [cbpg_pkg::PROD_W-1:0]    r_prod;
    cbpg_pkg::t_coord                      r_a;
    logic signed [cbpg_pkg::PROD_W-1:0]    w_rnd;
    logic signed [cbpg_pkg::PROD_W-cbpg_pkg::T_FRAC-1:0] w_scaled;
    logic signed [cbpg_pkg::PROD_W-cbpg_pkg::T_FRAC:0]   w_sum;
    cbpg_pkg::t_coord                      w_sat;
    cbpg_pkg::t_coord                      r_y;

    // Difference and product against t
    assign w_diff = {i_b[cbpg_pkg::COORD_W-1], i_b} - {i_a[cbpg_pkg::COORD_W-1], i_a};
    assign w_t    = {1'b0, i_t};
    assign w_prod = cbpg_pkg::PROD_W'(w_diff) * cbpg_pkg::PROD_W'(w_t);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= w_prod;
            r_a    <= i_a;
        end
    end

    // Round half up, floor by arithmetic shift, add base, saturate
    assign w_rnd    = r_prod + cbpg_pkg::PROD_W'(1 <<< (cbpg_pkg::T_FRAC - 1));
    assign w_scaled = w_rnd[cbpg_pkg::PROD_W-1:cbpg_pkg::T_FRAC];
    assign w_sum    = {{3{r_a[cbpg_pkg::COORD_W-1]}}, r_a}
                    + {w_scaled[cbpg_pkg::PROD_W-cbpg_pkg::T_FRAC-1], w_scaled};

    always_comb begin
        if (w_sum[cbpg_pkg::PROD_W-cbpg_pkg::T_FRAC:cbpg_pkg::COORD_W-1] == '0 ||
            w_sum[cbpg_pkg::PROD_W-cbpg_pkg::T_FRAC:cbpg_pkg::COORD_W-1] == '1) begin
            w_sat = w_sum[cbpg_pkg::COORD_W-1:0];
        end else if (w_sum[cbpg_pkg::PROD_W-cbpg_pkg::T_FRAC]) begin
            w_sat = {1'b1, {(cbpg_pkg::COORD_W-1){1'b0}}};
        end else begin
            w_sat = {1'b0, {(cbpg_pkg::COORD_W-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_y <= w_sat;
        end
    end

    assign o_y = r_y;

endmodule

`default_nettype wire

// File: hdl/cbpg_lane.sv
// One axis lane: de Casteljau evaluation as three levels of pipelined lerps.
// Depends on cbpg_pkg and cbpg_lerp.
`default_nettype none

module cbpg_lane (
    input  wire                  i_clk,
    input  wire                  i_en,
    input  cbpg_pkg::t_axis_pts  i_pts,
    input  cbpg_pkg::t_tval      i_t1,
    input  cbpg_pkg::t_tval      i_t2,
    input  cbpg_pkg::t_tval      i_t3,
    output cbpg_pkg::t_coord     o_y
);

    cbpg_pkg::t_coord w_a;
    cbpg_pkg::t_coord w_b;
    cbpg_pkg::t_coord w_c;
    cbpg_pkg::t_coord w_d;
    cbpg_pkg::t_coord w_e;

    // First level: along the control polygon
    cbpg_lerp u_l1_a (.i_clk(i_clk), .i_en(i_en), .i_a(i_pts.p0), .i_b(i_pts.c0),
                      .i_t(i_t1), .o_y(w_a));
    cbpg_lerp u_l1_b (.i_clk(i_clk), .i_en(i_en), .i_a(i_pts.c0), .i_b(i_pts.c1),
                      .i_t(i_t1), .o_y(w_b));
    cbpg_lerp u_l1_c (.i_clk(i_clk), .i_en(i_en), .i_a(i_pts.c1), .i_b(i_pts.p1),
                      .i_t(i_t1), .o_y(w_c));

    // Second level
    cbpg_lerp u_l2_d (.i_clk(i_clk), .i_en(i_en), .i_a(w_a), .i_b(w_b),
                      .i_t(i_t2), .o_y(w_d));
    cbpg_lerp u_l2_e (.i_clk(i_clk), .i_en(i_en), .i_a(w_b), .i_b(w_c),
                      .i_t(i_t2), .o_y(w_e));

    // Third level gives the curve point
    cbpg_lerp u_l3   (.i_clk(i_clk), .i_en(i_en), .i_a(w_d), .i_b(w_e),
                      .i_t(i_t3), .o_y(o_y));

endmodule

`default_nettype wire

// File: hdl/cbpg_tgen.sv
// Point sequencer: issues one t = round(k / S) per cycle while i_adv is high, exact,
// from a quotient/remainder accumulator. Depends on cbpg_pkg.
`default_nettype none

module cbpg_tgen #(
    parameter int MAX_POINTS = 64
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  cbpg_pkg::t_idx      i_step,
    input  wire                 i_start,
    input  wire                 i_adv,
    output cbpg_pkg::t_issue    o_issue
);

    localparam cbpg_pkg::t_idx S_MAX = cbpg_pkg::IDX_W'(MAX_POINTS - 1);

    // Constant tables: whole quotient and remainder of 1.0 / S
    cbpg_pkg::t_tval w_q_tab [cbpg_pkg::TAB_DEPTH];
    cbpg_pkg::t_idx  w_r_tab [cbpg_pkg::TAB_DEPTH];

    for (genvar gi = 0; gi < cbpg_pkg::TAB_DEPTH; gi++) begin : g_tab
        localparam int Div = (gi == 0) ? 1 : gi;
        localparam cbpg_pkg::t_tval QV = cbpg_pkg::T_W'(cbpg_pkg::T_ONE / Div);
        localparam cbpg_pkg::t_idx  RV = cbpg_pkg::IDX_W'(cbpg_pkg::T_ONE % Div);
        assign w_q_tab[gi] = QV;
        assign w_r_tab[gi] = RV;
    end

    logic            r_active, n_active;
    cbpg_pkg::t_idx  r_k, n_k;
    cbpg_pkg::t_idx  r_s, n_s;
    cbpg_pkg::t_tval r_q, n_q;
    cbpg_pkg::t_idx  r_r, n_r;
    cbpg_pkg::t_tval r_qinc, n_qinc;
    cbpg_pkg::t_idx  r_rinc, n_rinc;
    cbpg_pkg::t_idx  w_eff_s;
    logic [cbpg_pkg::IDX_W:0] w_rsum;
    logic            w_last;

    // Clamp the step count to 1 .. MAX_POINTS-1
    always_comb begin
        if (i_step == '0) begin
            w_eff_s = cbpg_pkg::IDX_W'(1);
        end else if (i_step > S_MAX) begin
            w_eff_s = S_MAX;
        end else begin
            w_eff_s = i_step;
        end
    end

    assign w_last = (r_k == r_s);
    assign w_rsum = {1'b0, r_r} + {1'b0, r_rinc};

    // Load a new curve, advance k and t by one step, or go idle after the last point
    always_comb begin
        n_active = r_active;
        n_k      = r_k;
        n_s      = r_s;
        n_q      = r_q;
        n_r      = r_r;
        n_qinc   = r_qinc;
        n_rinc   = r_rinc;
        if (i_start) begin
            n_active = 1'b1;
            n_k      = '0;
            n_s      = w_eff_s;
            n_q      = '0;
            n_r      = w_eff_s >> 1;
            n_qinc   = w_q_tab[w_eff_s];
            n_rinc   = w_r_tab[w_eff_s];
        end else if (i_adv && r_active) begin
            if (w_last) begin
                n_active = 1'b0;
            end else begin
                n_k = r_k + 1'b1;
                if (w_rsum >= {1'b0, r_s}) begin
                    n_r = cbpg_pkg::IDX_W'(w_rsum - {1'b0, r_s});
                    n_q = r_q + r_qinc + 1'b1;
                end else begin
                    n_r = w_rsum[cbpg_pkg::IDX_W-1:0];
                    n_q = r_q + r_qinc;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_k      <= '0;
            r_s      <= '0;
            r_q      <= '0;
            r_r      <= '0;
            r_qinc   <= '0;
            r_rinc   <= '0;
        end else begin
            r_active <= n_active;
            r_k      <= n_k;
            r_s      <= n_s;
            r_q      <= n_q;
            r_r      <= n_r;
            r_qinc   <= n_qinc;
            r_rinc   <= n_rinc;
        end
    end

    // At k = S the accumulator holds exactly 1.0, so the lanes return the end point
    assign o_issue.valid = r_active;
    assign o_issue.last  = w_last;
    assign o_issue.idx   = r_k;
    assign o_issue.t     = r_q;

endmodule

`default_nettype wire

// File: hdl/cubic_bezier_point_generator.sv
// Top level of the cubic Bezier point generator: input latch, sequencer,
// three axis lanes and the output register. Depends on cbpg_pkg, cbpg_tgen, cbpg_lane.
//
// Each accepted curve (start, two control points, end; signed Q16.16 per axis)
// produces S+1 points, S being step_count clamped to 1 .. MAX_POINTS-1. Point k
// is the curve at t = round(k/S) in unsigned Q1.16, evaluated exactly per axis by
// de Casteljau's three lerp levels with round-half-up and saturation; the final
// point (t = 1.0) is the end point and carries last_point. The sequencer issues
// one point per cycle while the output is not stalled, and the next curve is
// taken in the same cycle that its last point issues, with no gap.
// Results are independent of the binary point position. step_count is written
// over the cfg channel, which is always ready; write it only while the block is
// idle. A stall on the output freezes the whole pipeline.
`default_nettype none

module cubic_bezier_point_generator #(
    parameter int MAX_POINTS = 64
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    // configuration
    input  wire                    i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire [5:0]              i_cfg_step_count,
    // curve input
    input  wire                    i_in_valid,
    output logic                   o_in_stall,
    input  wire signed [31:0]      i_start_x,
    input  wire signed [31:0]      i_start_y,
    input  wire signed [31:0]      i_start_z,
    input  wire signed [31:0]      i_ctrl_a_x,
    input  wire signed [31:0]      i_ctrl_a_y,
    input  wire signed [31:0]      i_ctrl_a_z,
    input  wire signed [31:0]      i_ctrl_b_x,
    input  wire signed [31:0]      i_ctrl_b_y,
    input  wire signed [31:0]      i_ctrl_b_z,
    input  wire signed [31:0]      i_end_x,
    input  wire signed [31:0]      i_end_y,
    input  wire signed [31:0]      i_end_z,
    // point output
    output logic                   o_out_valid,
    input  wire                    i_out_stall,
    output logic [5:0]             o_point_index,
    output logic signed [31:0]     o_point_x,
    output logic signed [31:0]     o_point_y,
    output logic signed [31:0]     o_point_z,
    output logic                   o_last_point
);

    cbpg_pkg::t_idx      r_step_count;
    cbpg_pkg::t_axis_pts r_pts [3];
    cbpg_pkg::t_issue    w_issue;
    cbpg_pkg::t_issue    r_ctl [cbpg_pkg::PIPE_DEPTH];
    cbpg_pkg::t_coord    w_lane_y [3];
    logic                w_adv;
    logic                w_in_accept;

    logic                r_out_valid;
    cbpg_pkg::t_idx      r_out_idx;
    cbpg_pkg::t_coord    r_out_x;
    cbpg_pkg::t_coord    r_out_y;
    cbpg_pkg::t_coord    r_out_z;
    logic                r_out_last;

    // Configuration register, always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_count <= cbpg_pkg::STEP_RESET;
        end else if (i_cfg_valid) begin
            r_step_count <= i_cfg_step_count;
        end
    end

    // Advance the pipeline unless the output holds a point that is stalled
    assign w_adv       = !r_out_valid || !i_out_stall;
    // Take a new curve when idle or when the last point of this one issues
    assign o_in_stall  = w_issue.valid && !(w_adv && w_issue.last);
    assign w_in_accept = i_in_valid && !o_in_stall;

    // Latch the curve on transfer
    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_pts[0] <= '{p0: i_start_x, c0: i_ctrl_a_x, c1: i_ctrl_b_x, p1: i_end_x};
            r_pts[1] <= '{p0: i_start_y, c0: i_ctrl_a_y, c1: i_ctrl_b_y, p1: i_end_y};
            r_pts[2] <= '{p0: i_start_z, c0: i_ctrl_a_z, c1: i_ctrl_b_z, p1: i_end_z};
        end
    end

    cbpg_tgen #(
        .MAX_POINTS (MAX_POINTS)
    ) u_tgen (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (r_step_count),
        .i_start (w_in_accept),
        .i_adv   (w_adv),
        .o_issue (w_issue)
    );

    // Carry index, last flag and t beside the lane stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < cbpg_pkg::PIPE_DEPTH; i++) begin
                r_ctl[i] <= '0;
            end
        end else if (w_adv) begin
            r_ctl[0] <= w_issue;
            for (int i = 1; i < cbpg_pkg::PIPE_DEPTH; i++) begin
                r_ctl[i] <= r_ctl[i-1];
            end
        end
    end

    // One lane per axis
    for (genvar ga = 0; ga < 3; ga++) begin : g_lane
        cbpg_lane u_lane (
            .i_clk (i_clk),
            .i_en  (w_adv),
            .i_pts (r_pts[ga]),
            .i_t1  (w_issue.t),
            .i_t2  (r_ctl[1].t),
            .i_t3  (r_ctl[3].t),
            .o_y   (w_lane_y[ga])
        );
    end

    // Merge the lanes into the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_ctl[cbpg_pkg::PIPE_DEPTH-1].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && r_ctl[cbpg_pkg::PIPE_DEPTH-1].valid) begin
            r_out_idx  <= r_ctl[cbpg_pkg::PIPE_DEPTH-1].idx;
            r_out_last <= r_ctl[cbpg_pkg::PIPE_DEPTH-1].last;
            r_out_x    <= w_lane_y[0];
            r_out_y    <= w_lane_y[1];
            r_out_z    <= w_lane_y[2];
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_point_index = r_out_idx;
    assign o_point_x     = r_out_x;
    assign o_point_y     = r_out_y;
    assign o_point_z     = r_out_z;
    assign o_last_point  = r_out_last;

`ifndef ASSERT_OFF
    // The last point always sits at t = 1.0 exactly
    a_last_at_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_issue.valid && w_issue.last) |-> (w_issue.t == cbpg_pkg::T_W'(cbpg_pkg::T_ONE)))
        else $error("last point issued with t other than 1.0");

    // Points of one curve follow each other with consecutive indices
    a_idx_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ctl[0].valid && r_ctl[1].valid && !r_ctl[1].last)
            |-> (r_ctl[0].idx == cbpg_pkg::IDX_W'(r_ctl[1].idx + 1'b1)))
        else $error("point index gap inside a curve");

    // Every curve has at least two points
    a_no_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_last_point && (o_point_index == '0)))
        else $error("curve ended at point zero");
`endif

endmodule

`default_nettype wire

// File: tb/sv/cubic_bezier_point_generator_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for cubic_bezier_point_generator: sends curves under
// several step counts and idle patterns and checks every emitted point. Needs cbpg_pkg.
module cubic_bezier_point_generator_test;

    localparam int     CLK_HALF    = 4;
    localparam int     RESET_TICKS = 9;
    localparam int     QUIET_LIMIT = 3000;
    localparam int     HOLD_TICKS  = 400;
    localparam int     SETTLE      = 12;
    localparam int     MAX_STEP    = 63;
    localparam cbpg_pkg::t_coord COORD_MAX = 32'sh7fffffff;
    localparam cbpg_pkg::t_coord COORD_MIN = 32'sh80000000;

    // Coordinates of one curve: start, first control, second control, end; x y z each
    typedef cbpg_pkg::t_coord t_curve [0:11];

    typedef struct packed {
        cbpg_pkg::t_idx   idx;
        cbpg_pkg::t_coord x;
        cbpg_pkg::t_coord y;
        cbpg_pkg::t_coord z;
        logic             last;
    } t_point;

    logic       i_clk     = 1'b0;
    logic       i_rst_n   = 1'b0;
    logic       cfg_valid = 1'b0;
    logic [5:0] cfg_step  = '0;
    logic       in_valid  = 1'b0;
    cbpg_pkg::t_coord coord_in [0:11] = '{default: '0};
    logic       out_stall = 1'b0;
    wire        cfg_ready;
    wire        in_stall;
    wire        out_valid;
    wire  [5:0] out_idx;
    wire signed [31:0] out_x;
    wire signed [31:0] out_y;
    wire signed [31:0] out_z;
    wire        out_last;

    t_point      pending_points [$];
    int unsigned step_shadow    = cbpg_pkg::STEP_RESET;
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    int          hold_asked     = 0;
    int          hold_taken     = 0;
    int          hold_left      = 0;
    int          quiet_cycles   = 0;
    int          errors         = 0;
    int          curves_sent    = 0;
    int          points_checked = 0;
    int          step_writes    = 0;

    cubic_bezier_point_generator u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (cfg_valid),
        .o_cfg_ready      (cfg_ready),
        .i_cfg_step_count (cfg_step),
        .i_in_valid       (in_valid),
        .o_in_stall       (in_stall),
        .i_start_x        (coord_in[0]),
        .i_start_y        (coord_in[1]),
        .i_start_z        (coord_in[2]),
        .i_ctrl_a_x       (coord_in[3]),
        .i_ctrl_a_y       (coord_in[4]),
        .i_ctrl_a_z       (coord_in[5]),
        .i_ctrl_b_x       (coord_in[6]),
        .i_ctrl_b_y       (coord_in[7]),
        .i_ctrl_b_z       (coord_in[8]),
        .i_end_x          (coord_in[9]),
        .i_end_y          (coord_in[10]),
        .i_end_z          (coord_in[11]),
        .o_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .o_point_index    (out_idx),
        .o_point_x        (out_x),
        .o_point_y        (out_y),
        .o_point_z        (out_z),
        .o_last_point     (out_last)
    );

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // One interpolation step: a + round-half-up((b - a) * t), saturated to 32 bits
    function automatic longint lerp_sat(longint a, longint b, longint t);
        longint q;
        longint r;
        q = (b - a) * t + (longint'(1) << (cbpg_pkg::T_FRAC - 1));
        r = a + (q >>> cbpg_pkg::T_FRAC);
        if (r > 64'sd2147483647)
            r = 64'sd2147483647;
        else if (r < -64'sd2147483648)
            r = -64'sd2147483648;
        return r;
    endfunction

    // Three de Casteljau levels on one axis
    function automatic longint bezier_coord(longint p0, longint c0, longint c1,
                                            longint p1, longint t);
        longint a;
        longint b;
        longint c;
        a = lerp_sat(p0, c0, t);
        b = lerp_sat(c0, c1, t);
        c = lerp_sat(c1, p1, t);
        return lerp_sat(lerp_sat(a, b, t), lerp_sat(b, c, t), t);
    endfunction

    // Queue every point that one accepted curve must produce
    task automatic queue_curve_points(input t_curve c);
        longint s;
        longint t;
        t_point p;
        s = step_shadow;
        if (s == 0)
            s = 1;
        if (s > MAX_STEP)
            s = MAX_STEP;
        for (longint k = 0; k < s; k++) begin
            t      = ((k << cbpg_pkg::T_FRAC) + s / 2) / s;
            p.idx  = cbpg_pkg::t_idx'(k);
            p.x    = cbpg_pkg::t_coord'(bezier_coord(c[0], c[3], c[6], c[9], t));
            p.y    = cbpg_pkg::t_coord'(bezier_coord(c[1], c[4], c[7], c[10], t));
            p.z    = cbpg_pkg::t_coord'(bezier_coord(c[2], c[5], c[8], c[11], t));
            p.last = 1'b0;
            pending_points = {pending_points, p};
        end
        p.idx  = cbpg_pkg::t_idx'(s);
        p.x    = c[9];
        p.y    = c[10];
        p.z    = c[11];
        p.last = 1'b1;
        pending_points = {pending_points, p};
    endtask

    // Offer one curve, after a random idle gap, and hold it until the transfer
    task automatic send_curve(input t_curve c);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        for (int i = 0; i < 12; i++)
            coord_in[i] <= c[i];
        @(posedge i_clk);
        while (in_stall)
            @(posedge i_clk);
        queue_curve_points(c);
        curves_sent++;
    endtask

    // Drop valid and wait until every queued point is out, then let the pipe settle
    task automatic drain_points();
        in_valid <= 1'b0;
        while (pending_points.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_step_count(input logic [5:0] value);
        cfg_valid <= 1'b1;
        cfg_step  <= value;
        @(posedge i_clk);
        while (!cfg_ready)
            @(posedge i_clk);
        cfg_valid   <= 1'b0;
        step_shadow = value;
        step_writes++;
    endtask

    // x follows the given values, y their bitwise inverse, z stays at zero
    function automatic t_curve axis_curve(cbpg_pkg::t_coord p0, cbpg_pkg::t_coord c0,
                                          cbpg_pkg::t_coord c1, cbpg_pkg::t_coord p1);
        t_curve c;
        c = '{default: '0};
        c[0] = p0;  c[3] = c0;  c[6] = c1;  c[9]  = p1;
        c[1] = ~p0; c[4] = ~c0; c[7] = ~c1; c[10] = ~p1;
        return c;
    endfunction

    function automatic cbpg_pkg::t_coord random_coord();
        case ($urandom_range(5))
            0, 1: return cbpg_pkg::t_coord'($urandom);
            2:    return COORD_MAX - cbpg_pkg::t_coord'($urandom_range(3));
            3:    return COORD_MIN + cbpg_pkg::t_coord'($urandom_range(3));
            default: return cbpg_pkg::t_coord'(int'($urandom_range(2097152)) - 1048576);
        endcase
    endfunction

    // Mostly full 3D curves; now and then a flat one with z at zero
    function automatic t_curve random_curve();
        t_curve c;
        bit     flat;
        flat = ($urandom_range(9) == 0);
        foreach (c[i])
            c[i] = (flat && (i % 3 == 2)) ? cbpg_pkg::t_coord'(0) : random_coord();
        return c;
    endfunction

    function automatic logic [5:0] random_step_count();
        case ($urandom_range(7))
            0:       return 6'd0;
            1:       return 6'(MAX_STEP);
            2:       return 6'($urandom_range(MAX_STEP));
            default: return 6'($urandom_range(1, 8));
        endcase
    endfunction

    task automatic run_random(input int count, input int idle_pct, input int stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < count; i++) begin
            if (i % 20 == 0) begin
                drain_points();
                write_step_count(random_step_count());
            end
            send_curve(random_curve());
        end
        drain_points();
    endtask

    // Reset step count: field extremes, saturating spans, a line, rounding ties
    task automatic test_reset_step_count();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_curve(axis_curve(0, 0, 0, 0));
        send_curve(axis_curve(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
        send_curve(axis_curve(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX));
        send_curve(axis_curve(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX));
        send_curve(axis_curve(0, 32'sh10000, 32'sh20000, 32'sh30000));
        send_curve(axis_curve(-1, 1, -1, 1));
        send_curve(random_curve());
        send_curve(random_curve());
        drain_points();
    endtask

    // Zero step count acts as one; one step; the largest step count
    task automatic test_step_extremes();
        write_step_count(6'd0);
        send_curve(axis_curve(COORD_MIN, 0, 0, COORD_MAX));
        send_curve(random_curve());
        send_curve(random_curve());
        drain_points();
        write_step_count(6'd1);
        send_curve(axis_curve(COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN));
        send_curve(random_curve());
        drain_points();
        write_step_count(6'(MAX_STEP));
        send_curve(axis_curve(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX));
        send_curve(axis_curve(1, -1, 1, -1));
        send_curve(random_curve());
        drain_points();
    endtask

    task automatic test_random_no_idle();
        run_random(110, 0, 0);
    endtask

    task automatic test_random_sender_idle();
        run_random(110, 51, 0);
    endtask

    task automatic test_random_receiver_stall();
        run_random(110, 0, 51);
    endtask

    task automatic test_random_both_idle();
        run_random(110, 15, 15);
    endtask

    // Long receiver hold while curves keep coming, so the input side backs up
    task automatic test_output_backpressure();
        write_step_count(6'd4);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_asked++;
        for (int i = 0; i < 40; i++)
            send_curve(random_curve());
        drain_points();
        write_step_count(cbpg_pkg::STEP_RESET);
        send_curve(random_curve());
        drain_points();
    endtask

    // Receiver stall: a requested long hold first, random stalls otherwise
    always @(posedge i_clk) begin
        if (hold_asked != hold_taken) begin
            hold_taken <= hold_asked;
            hold_left  <= HOLD_TICKS;
            out_stall  <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    function automatic void check_field(string name, longint want, longint got);
        if (want != got) begin
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    // Compare each point transfer with the oldest queued point
    always @(posedge i_clk) begin : check_point
        t_point want;
        if (i_rst_n && out_valid && !out_stall) begin
            if (pending_points.size() == 0) begin
                $display("%0t: unexpected point: expected none, got idx %0d (%0d %0d %0d)",
                         $time, out_idx, out_x, out_y, out_z);
                errors++;
            end else begin
                want = pending_points.pop_front();
                check_field("point_index", want.idx, out_idx);
                check_field("point_x", want.x, out_x);
                check_field("point_y", want.y, out_y);
                check_field("point_z", want.z, out_z);
                check_field("last_point", want.last, out_last);
                points_checked++;
            end
        end
    end

    // Watchdog: end the run after too many cycles without any transfer
    always @(posedge i_clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no transfer for %0d cycles, %0d points outstanding",
                     $time, quiet_cycles, pending_points.size());
            $display("cubic_bezier_point_generator_test: errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (RESET_TICKS) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_step_count();
        test_step_extremes();
        test_random_no_idle();
        test_random_sender_idle();
        test_random_receiver_stall();
        test_random_both_idle();
        test_output_backpressure();
        $display("Covered %0d curves and %0d points over %0d step count writes,",
                 curves_sent, points_checked, step_writes);
        $display("with sender gaps, receiver stalls and one long output hold; %0d errors.",
                 errors);
        if (errors == 0)
            $display("cubic_bezier_point_generator_test: clean");
        else
            $display("cubic_bezier_point_generator_test: errors");
        $finish;
    end

endmodule

// File: files.f
hdl/cbpg_pkg.sv
hdl/cbpg_lerp.sv
hdl/cbpg_lane.sv
hdl/cbpg_tgen.sv
hdl/cubic_bezier_point_generator.sv
tb/sv/cubic_bezier_point_generator_test.sv
